FILE: design/clch_pkg.sv
// shared types and constants for the color level and chroma histogram
`timescale 1ns / 1ps
package clch_pkg;

  // command codes
  localparam logic [1:0] CMD_ACCUM = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_X_MIN  = 3'd1;
  localparam logic [2:0] REG_X_MAX  = 3'd2;
  localparam logic [2:0] REG_Y_MIN  = 3'd3;
  localparam logic [2:0] REG_Y_MAX  = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LVL_DIV,
    ST_LVL_RD,
    ST_LVL_WAIT,
    ST_LVL_WR,
    ST_CH_DIV,
    ST_CH_RD,
    ST_CH_WAIT,
    ST_CH_WR,
    ST_RD_WAIT,
    ST_RD_DONE,
    ST_DONE
  } state_e;

endpackage

FILE: design/clch_divider.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module clch_divider import clch_pkg::*; #(
  parameter int NumBits = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] dividend_i,
  input  logic [NumBits-1:0] divisor_i,
  output logic               done_o,
  output logic [NumBits-1:0] quotient_o
);
  localparam int CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quo_q, quo_d, div_q, div_d;
  logic [NumBits:0]   rem_q, rem_d, trial;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;

  // one shift-subtract step
  always_comb begin
    trial  = {rem_q[NumBits-1:0], quo_q[NumBits-1]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = trial - {1'b0, div_q};
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

FILE: design/color_level_chroma_histogram.sv
// top level: color level and chroma histograms with peak tracking
`timescale 1ns / 1ps
// Usage: drive command_i, the coordinates, the pixel and bin_index_i with start
// while busy is low; the item is taken at that edge and busy rises. Exactly one
// result per item appears on the result ports with done_o high for one cycle,
// and busy falls at the edge that ends it. The receiver cannot stall.
// Configuration goes over cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; ready is high always, writes are meant for idle time.
// Item paths: a read passes a wait state and a done state; a pixel outside
// the window, a disabled pixel or an unused command goes straight to the done
// state; a clear zeroes every bin, then ends in the done state. A counted pixel
// finds its level by reciprocal multiply, makes 2*SPREAD+1 read-modify-write
// passes at most over the one histogram memory port, takes a setup step, then
// per color runs a 20-step shift-subtract division (none for a black pixel)
// and a read-modify-write update.
// After reset a clearing pass over all HIST_BINS bins runs with busy high;
// configuration registers take their reset values at once.
module color_level_chroma_histogram import clch_pkg::*; #(
  parameter int HIST_BINS  = 256,
  parameter int IMAGE_ROWS = 512,
  parameter int SPREAD     = 5,
  parameter int COUNT_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic [1:0]  command_i,
  input  logic [7:0]  column_i,
  input  logic [8:0]  row_i,
  input  logic [7:0]  pix_red_i,
  input  logic [7:0]  pix_green_i,
  input  logic [7:0]  pix_blue_i,
  input  logic [7:0]  bin_index_i,
  output logic        counted_o,
  output logic [19:0] level_peak_o,
  output logic [7:0]  level_peak_bin_o,
  output logic [19:0] red_peak_o,
  output logic [19:0] green_peak_o,
  output logic [19:0] blue_peak_o,
  output logic [19:0] bin_level_count_o,
  output logic [19:0] bin_red_count_o,
  output logic [19:0] bin_green_count_o,
  output logic [19:0] bin_blue_count_o
);
  localparam int AW = $clog2(HIST_BINS);
  localparam int CW = COUNT_BITS;
  localparam int DW = 20;
  localparam int MW = 4 * CW;
  localparam logic [CW-1:0] CntMax = {CW{1'b1}};
  localparam logic [AW-1:0] LastBin = AW'(HIST_BINS - 1);
  localparam logic [AW-1:0] HalfBin = AW'(HIST_BINS / 2 - 1);
  localparam logic [8:0] RowLast = 9'((IMAGE_ROWS - 1 > 511) ? 511 : IMAGE_ROWS - 1);
  // level = floor(sum * (bins-1) / 765) as (sum * (bins-1) * ceil(2^30/765)) >> 30
  localparam logic [20:0] LvlRecip = 21'(((64'd1 << 30) + 64'd764) / 64'd765);
  localparam logic [30:0] LvlMul   = 31'(HIST_BINS - 1) * LvlRecip;

  // configuration registers
  logic       enable_q;
  logic [7:0] x_min_q, x_max_q;
  logic [8:0] y_min_q, y_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      x_min_q  <= 8'd96;
      x_max_q  <= 8'd160;
      y_min_q  <= 9'd0;
      y_max_q  <= 9'd32;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENABLE: enable_q <= cfg_data_i[0];
        REG_X_MIN:  x_min_q  <= cfg_data_i[7:0];
        REG_X_MAX:  x_max_q  <= cfg_data_i[7:0];
        REG_Y_MIN:  y_min_q  <= cfg_data_i;
        REG_Y_MAX:  y_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // histogram memory: four counters per word, one port
  logic [MW-1:0] mem [HIST_BINS];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [MW-1:0] mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata_q <= mem[mem_addr];
  end

  // shared divider
  logic          div_start, div_done;
  logic [DW-1:0] div_num, div_den, div_quo;

  clch_divider #(.NumBits(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer state
  state_e        state_q, state_d;
  logic [AW:0]   ptr_q, ptr_d;
  logic [AW-1:0] hi_q, hi_d;
  logic [1:0]    ch_q, ch_d;
  logic [7:0]    r_q, g_q, b_q;
  logic [1:0]    cmd_q;
  logic [7:0]    idx_q;
  logic          counted_q, counted_d;
  logic [CW-1:0] ltop_q, ltop_d, rtop_q, rtop_d, gtop_q, gtop_d, btop_q, btop_d;
  logic [AW-1:0] lbin_q, lbin_d;
  logic [AW-1:0] cbin_q, cbin_d;
  logic          rd_ok_q;

  logic [9:0]    sum;
  logic [40:0]   lvl_prod;
  logic [AW:0]   lvl;
  logic [CW-1:0] cur, inc;
  logic [7:0]    cc, o1, o2;
  logic [AW:0]   lo_w, hi_w;
  logic          in_win;

  assign sum = 10'(r_q) + 10'(g_q) + 10'(b_q);

  // brightness level by reciprocal multiply, exact over all sums
  assign lvl_prod = 41'(sum) * 41'(LvlMul);
  assign lvl      = lvl_prod[30 +: AW+1];

  // channel selection for the chroma pass
  always_comb begin
    unique case (ch_q)
      2'd0:    begin cc = r_q; o1 = g_q; o2 = b_q; end
      2'd1:    begin cc = g_q; o1 = r_q; o2 = b_q; end
      default: begin cc = b_q; o1 = r_q; o2 = g_q; end
    endcase
  end

  assign cur = (state_q == ST_LVL_WR) ? mem_rdata_q[CW-1:0]
             : mem_rdata_q[(32'(ch_q) + 1) * CW +: CW];
  assign inc = (cur == CntMax) ? CntMax : cur + 1'b1;

  assign in_win = enable_q && column_i >= x_min_q && column_i <= x_max_q &&
                  row_i >= y_min_q &&
                  row_i <= ((y_max_q > RowLast) ? RowLast : y_max_q);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    hi_d      = hi_q;
    ch_d      = ch_q;
    counted_d = counted_q;
    ltop_d = ltop_q; rtop_d = rtop_q; gtop_d = gtop_q; btop_d = btop_q;
    lbin_d = lbin_q;
    cbin_d = cbin_q;
    mem_we    = 1'b0;
    mem_addr  = ptr_q[AW-1:0];
    mem_wdata = mem_rdata_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    lo_w      = '0;
    hi_w      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          counted_d = 1'b0;
          unique case (command_i)
            CMD_ACCUM: if (in_win) begin
              counted_d = 1'b1;
              state_d   = ST_LVL_DIV;
            end else state_d = ST_DONE;
            CMD_CLEAR: begin
              ptr_d = '0;
              state_d = ST_CLEAR;
            end
            CMD_READ: begin
              mem_addr = AW'(bin_index_i);
              state_d  = ST_RD_WAIT;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        ltop_d = '0; rtop_d = '0; gtop_d = '0; btop_d = '0; lbin_d = '0;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q[AW-1:0] == LastBin) state_d = (cmd_q == CMD_CLEAR) ? ST_DONE : ST_IDLE;
      end
      // spread window around the level, clipped to the bins
      ST_LVL_DIV: begin
        lo_w  = (lvl >= (AW+1)'(SPREAD)) ? lvl - (AW+1)'(SPREAD) : '0;
        hi_w  = lvl + (AW+1)'(SPREAD);
        ptr_d = lo_w;
        hi_d  = (hi_w > {1'b0, LastBin}) ? LastBin : hi_w[AW-1:0];
        state_d = ST_LVL_RD;
      end
      ST_LVL_RD:   state_d = ST_LVL_WAIT;
      ST_LVL_WAIT: state_d = ST_LVL_WR;
      ST_LVL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {mem_rdata_q[MW-1:CW], inc};
        if (inc >= ltop_q) begin
          ltop_d = inc;
          lbin_d = ptr_q[AW-1:0];
        end
        if (ptr_q[AW-1:0] == hi_q) begin
          ch_d    = 2'd3;
          state_d = ST_CH_DIV;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          state_d = ST_LVL_RD;
        end
      end
      ST_CH_DIV: begin
        div_num = (DW'(cc) * 20'd4 + DW'(o1) + DW'(o2)) * DW'(HIST_BINS / 2 - 1);
        div_den = DW'(sum) * 20'd2;
        if (ch_q == 2'd3) begin
          ch_d = 2'd0;
        end else if (sum == '0) begin
          cbin_d  = HalfBin;
          state_d = ST_CH_RD;
        end else if (div_done) begin
          cbin_d  = (div_quo > DW'(HIST_BINS - 1)) ? LastBin : div_quo[AW-1:0];
          state_d = ST_CH_RD;
        end else begin
          div_start = (ptr_q[AW] == 1'b0);
          ptr_d[AW] = 1'b1;
        end
      end
      ST_CH_RD: begin
        mem_addr = cbin_q;
        state_d  = ST_CH_WAIT;
      end
      ST_CH_WAIT: begin
        mem_addr = cbin_q;
        state_d  = ST_CH_WR;
      end
      ST_CH_WR: begin
        mem_addr  = cbin_q;
        mem_we    = 1'b1;
        mem_wdata = mem_rdata_q;
        mem_wdata[(32'(ch_q) + 1) * CW +: CW] = inc;
        unique case (ch_q)
          2'd0:    if (inc > rtop_q) rtop_d = inc;
          2'd1:    if (inc > gtop_q) gtop_d = inc;
          default: if (inc > btop_q) btop_d = inc;
        endcase
        ptr_d[AW] = 1'b0;
        if (ch_q == 2'd2) state_d = ST_DONE;
        else begin
          ch_d    = ch_q + 1'b1;
          state_d = ST_CH_DIV;
        end
      end
      ST_RD_WAIT: begin
        mem_addr = AW'(idx_q);
        state_d  = ST_RD_DONE;
      end
      ST_RD_DONE: state_d = ST_IDLE;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ptr_q     <= '0;
      hi_q      <= '0;
      ch_q      <= 2'd3;
      cmd_q     <= '0;
      counted_q <= 1'b0;
      ltop_q <= '0; rtop_q <= '0; gtop_q <= '0; btop_q <= '0;
      lbin_q <= '0;
      cbin_q <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      hi_q      <= hi_d;
      ch_q      <= (state_q == ST_IDLE) ? 2'd3 : ch_d;
      counted_q <= counted_d;
      ltop_q <= ltop_d; rtop_q <= rtop_d; gtop_q <= gtop_d; btop_q <= btop_d;
      lbin_q <= lbin_d;
      cbin_q <= cbin_d;
      if (state_q == ST_IDLE && start) cmd_q <= command_i;
    end
  end

  // item payload capture
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      r_q     <= pix_red_i;
      g_q     <= pix_green_i;
      b_q     <= pix_blue_i;
      idx_q   <= bin_index_i;
      rd_ok_q <= 32'(bin_index_i) < 32'(HIST_BINS);
    end
  end

  // result ports
  logic rd_show;
  assign rd_show = (state_q == ST_RD_DONE) && rd_ok_q;

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE) || (state_q == ST_RD_DONE);
  assign counted_o         = counted_q && (state_q == ST_DONE);
  assign level_peak_o      = DW'(ltop_q);
  assign level_peak_bin_o  = 8'(lbin_q);
  assign red_peak_o        = DW'(rtop_q);
  assign green_peak_o      = DW'(gtop_q);
  assign blue_peak_o       = DW'(btop_q);
  assign bin_level_count_o = rd_show ? DW'(mem_rdata_q[0*CW +: CW]) : '0;
  assign bin_red_count_o   = rd_show ? DW'(mem_rdata_q[1*CW +: CW]) : '0;
  assign bin_green_count_o = rd_show ? DW'(mem_rdata_q[2*CW +: CW]) : '0;
  assign bin_blue_count_o  = rd_show ? DW'(mem_rdata_q[3*CW +: CW]) : '0;
endmodule

FILE: bench/tb_top.sv
// self-checking bench for the color level and chroma histogram block
`timescale 1ns / 1ps
module tb_top;
  import clch_pkg::*;

  localparam int NBINS    = 256;
  localparam int NROWS    = 512;
  localparam int WIDEN    = 5;
  localparam logic [19:0] CMAX = 20'hFFFFF;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 400;

  typedef struct packed {
    logic        counted;
    logic [19:0] lpeak;
    logic [7:0]  lbin;
    logic [19:0] rpeak;
    logic [19:0] gpeak;
    logic [19:0] bpeak;
    logic [19:0] clvl;
    logic [19:0] cred;
    logic [19:0] cgrn;
    logic [19:0] cblu;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, done_o, cfg_ready_o;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;
  logic [1:0] command_i = '0;
  logic [7:0] column_i = '0;
  logic [8:0] row_i = '0;
  logic [7:0] pix_red_i = '0, pix_green_i = '0, pix_blue_i = '0, bin_index_i = '0;
  stats_t got;

  color_level_chroma_histogram u_dut (
    .clk_i, .rst_ni, .start, .busy, .done_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .command_i, .column_i, .row_i, .pix_red_i,
    .pix_green_i, .pix_blue_i, .bin_index_i,
    .counted_o(got.counted), .level_peak_o(got.lpeak), .level_peak_bin_o(got.lbin),
    .red_peak_o(got.rpeak), .green_peak_o(got.gpeak), .blue_peak_o(got.bpeak),
    .bin_level_count_o(got.clvl), .bin_red_count_o(got.cred),
    .bin_green_count_o(got.cgrn), .bin_blue_count_o(got.cblu)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic        m_en;
  logic [7:0]  m_xmin, m_xmax;
  logic [8:0]  m_ymin, m_ymax;
  logic [19:0] h_lvl [NBINS];
  logic [19:0] h_red [NBINS];
  logic [19:0] h_grn [NBINS];
  logic [19:0] h_blu [NBINS];
  logic [19:0] t_lvl, t_red, t_grn, t_blu;
  logic [7:0]  t_lbin;

  stats_t expected_stats[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle = 0;

  function automatic logic [19:0] sat_up(logic [19:0] v);
    return (v == CMAX) ? CMAX : v + 20'd1;
  endfunction

  function automatic int chroma_of(int c, int o1, int o2);
    int s, b;
    s = c + o1 + o2;
    if (s == 0) return NBINS / 2 - 1;
    b = ((4 * c + o1 + o2) * (NBINS / 2 - 1)) / (2 * s);
    return (b >= NBINS) ? NBINS - 1 : b;
  endfunction

  task automatic wipe_stats();
    for (int i = 0; i < NBINS; i++) begin
      h_lvl[i] = '0; h_red[i] = '0; h_grn[i] = '0; h_blu[i] = '0;
    end
    t_lvl = '0; t_red = '0; t_grn = '0; t_blu = '0; t_lbin = '0;
  endtask

  task automatic bump_chroma(ref logic [19:0] h [NBINS], ref logic [19:0] top, input int b);
    h[b] = sat_up(h[b]);
    if (h[b] > top) top = h[b];
  endtask

  // statistics update for one item, pushes the expected result
  task automatic predict_stats(logic [1:0] cmd, logic [7:0] col, logic [8:0] row,
                               int r, int g, int b, logic [7:0] idx);
    stats_t e;
    int lvl, lo, hi;
    logic [8:0] ylim;
    e = '0;
    ylim = (m_ymax > NROWS - 1) ? 9'(NROWS - 1) : m_ymax;
    if (cmd == CMD_ACCUM) begin
      if (m_en && col >= m_xmin && col <= m_xmax && row >= m_ymin && row <= ylim) begin
        lvl = ((NBINS - 1) * (r + g + b)) / 765;
        lo = (lvl - WIDEN < 0) ? 0 : lvl - WIDEN;
        hi = (lvl + WIDEN > NBINS - 1) ? NBINS - 1 : lvl + WIDEN;
        for (int k = lo; k <= hi; k++) begin
          h_lvl[k] = sat_up(h_lvl[k]);
          if (h_lvl[k] >= t_lvl) begin
            t_lvl = h_lvl[k]; t_lbin = 8'(k);
          end
        end
        bump_chroma(h_red, t_red, chroma_of(r, g, b));
        bump_chroma(h_grn, t_grn, chroma_of(g, r, b));
        bump_chroma(h_blu, t_blu, chroma_of(b, r, g));
        e.counted = 1'b1;
      end
    end else if (cmd == CMD_CLEAR) begin
      wipe_stats();
    end else if (cmd == CMD_READ) begin
      e.clvl = h_lvl[idx]; e.cred = h_red[idx]; e.cgrn = h_grn[idx]; e.cblu = h_blu[idx];
    end
    e.lpeak = t_lvl; e.lbin = t_lbin; e.rpeak = t_red; e.gpeak = t_grn; e.bpeak = t_blu;
    expected_stats.push_back(e);
  endtask

  // one command transfer
  task automatic send_item(logic [1:0] cmd, logic [7:0] col, logic [8:0] row,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] idx);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk_i);
    command_i <= cmd; column_i <= col; row_i <= row;
    pix_red_i <= r; pix_green_i <= g; pix_blue_i <= b; bin_index_i <= idx;
    start <= 1'b1;
    // busy is stable at the falling edge; the next rising edge takes the item
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predict_stats(cmd, col, row, r, g, b, idx);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // register write while idle
  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    cfg_index_i <= idx; cfg_data_i <= val; cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_ENABLE: m_en = val[0];
      REG_X_MIN:  m_xmin = val[7:0];
      REG_X_MAX:  m_xmax = val[7:0];
      REG_Y_MIN:  m_ymin = val;
      REG_Y_MAX:  m_ymax = val;
      default: ;
    endcase
  endtask

  task automatic set_window(logic en, logic [7:0] x0, logic [7:0] x1,
                            logic [8:0] y0, logic [8:0] y1);
    drain();
    write_reg(REG_ENABLE, {8'd0, en});
    write_reg(REG_X_MIN, {1'b0, x0});
    write_reg(REG_X_MAX, {1'b0, x1});
    write_reg(REG_Y_MIN, y0);
    write_reg(REG_Y_MAX, y1);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        stats_t e;
        e = expected_stats.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", e, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_special_cases();
    send_item(CMD_ACCUM, 8'd100, 9'd5, 8'd10, 8'd20, 8'd30, 8'd0);    // disabled
    send_item(CMD_READ, 8'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    set_window(1'b1, 8'd0, 8'd255, 9'd0, 9'd511);
    send_item(CMD_ACCUM, 8'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0);         // black pixel
    send_item(CMD_ACCUM, 8'd255, 9'd511, 8'd255, 8'd255, 8'd255, 8'd0);
    send_item(CMD_ACCUM, 8'd7, 9'd300, 8'd255, 8'd0, 8'd0, 8'd0);
    send_item(CMD_ACCUM, 8'd7, 9'd300, 8'd0, 8'd255, 8'd0, 8'd0);
    send_item(CMD_ACCUM, 8'd7, 9'd300, 8'd0, 8'd0, 8'd255, 8'd0);
    send_item(CMD_ACCUM, 8'd7, 9'd300, 8'd128, 8'd128, 8'd127, 8'd0);
    send_item(CMD_READ, 8'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd127);
    send_item(CMD_READ, 8'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    send_item(CMD_READ, 8'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(CMD_NONE, 8'd255, 9'd511, 8'd255, 8'd255, 8'd255, 8'd255);
    set_window(1'b0, 8'd0, 8'd255, 9'd0, 9'd511);
    send_item(CMD_CLEAR, 8'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0);         // clear while disabled
    send_item(CMD_READ, 8'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    set_window(1'b1, 8'd200, 8'd100, 9'd0, 9'd511);                   // empty columns
    send_item(CMD_ACCUM, 8'd150, 9'd10, 8'd1, 8'd2, 8'd3, 8'd0);
    set_window(1'b1, 8'd0, 8'd255, 9'd400, 9'd300);                   // empty rows
    send_item(CMD_ACCUM, 8'd150, 9'd350, 8'd1, 8'd2, 8'd3, 8'd0);
    set_window(1'b1, 8'd255, 8'd255, 9'd511, 9'd511);                 // corner only
    send_item(CMD_ACCUM, 8'd255, 9'd511, 8'd90, 8'd3, 8'd200, 8'd0);
    send_item(CMD_ACCUM, 8'd254, 9'd511, 8'd90, 8'd3, 8'd200, 8'd0);
  endtask

  task automatic test_random(int n, int s_idle);
    int pick;
    logic [1:0] cmd;
    send_idle = s_idle;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      cmd = (pick < 70) ? CMD_ACCUM : (pick < 93) ? CMD_READ : (pick < 96) ? CMD_NONE
                                                                         : CMD_CLEAR;
      send_item(cmd, 8'($urandom), 9'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_windows();
    set_window(1'b1, 8'd0, 8'd255, 9'd0, 9'd511);
    test_random(400, 15);
    set_window(1'b1, 8'd64, 8'd191, 9'd100, 9'd300);
    test_random(400, 45);
    set_window(1'b1, 8'd96, 8'd160, 9'd0, 9'd32);
    test_random(300, 0);
    set_window(1'b0, 8'd0, 8'd255, 9'd0, 9'd511);
    test_random(100, 0);
    set_window(1'b1, 8'd0, 8'd255, 9'd0, 9'd511);
    test_random(400, 0);
    send_item(CMD_READ, 8'd0, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  initial begin
    m_en = 1'b0; m_xmin = 8'd96; m_xmax = 8'd160; m_ymin = 9'd0; m_ymax = 9'd32;
    wipe_stats();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_windows();
    drain();
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/clch_pkg.sv
design/clch_divider.sv
design/color_level_chroma_histogram.sv
bench/tb_top.sv
